### rtl/lps_pkg.sv
// ----------------------------------------------------------------------------
// lps_pkg
// Shared types and codes for the LED pattern sequencer: transaction payloads,
// configuration register set, frame store word and event codes.
// ----------------------------------------------------------------------------
package lps_pkg;

   localparam int NUM_PATTERNS_DEF = 8;
   localparam int MAX_FRAMES_DEF   = 16;
   localparam int MAX_LEDS         = 8;
   localparam int FIFO_DEPTH       = 3;
   localparam int CSR_ADDR_WIDTH   = 5;

   localparam logic [15:0] START_DELAY_RESET = 16'd4000;
   localparam logic [3:0]  LED_COUNT_RESET   = 4'd8;

   // item kinds
   localparam logic [2:0] KIND_TICK         = 3'd0;
   localparam logic [2:0] KIND_FRAME_WRITE  = 3'd1;
   localparam logic [2:0] KIND_VEHICLE_MODE = 3'd2;
   localparam logic [2:0] KIND_POWER_OP     = 3'd3;
   localparam logic [2:0] KIND_ENTITY_STATE = 3'd4;

   // pattern numbers
   localparam logic [2:0] PTN_NORMAL     = 3'd0;
   localparam logic [2:0] PTN_ERROR      = 3'd1;
   localparam logic [2:0] PTN_FATAL      = 3'd2;
   localparam logic [2:0] PTN_SHUTDOWN   = 3'd3;
   localparam logic [2:0] PTN_PLAN_START = 3'd4;
   localparam logic [2:0] PTN_PLAN_EXEC  = 3'd5;

   // vehicle modes
   localparam logic [2:0] MODE_SERVICE     = 3'd0;
   localparam logic [2:0] MODE_CALIBRATION = 3'd1;
   localparam logic [2:0] MODE_ERROR       = 3'd2;
   localparam logic [2:0] MODE_MANEUVER    = 3'd3;
   localparam logic [2:0] MODE_EXTERNAL    = 3'd4;
   localparam logic [2:0] MODE_BOOT        = 3'd5;

   // power operations
   localparam logic [1:0] POWER_DOWN_IP      = 2'd0;
   localparam logic [1:0] POWER_DOWN_ABORTED = 2'd1;

   // register indexes
   localparam logic [2:0] REG_LED_COUNT       = 3'd0;
   localparam logic [2:0] REG_SYSTEM_ID       = 3'd1;
   localparam logic [2:0] REG_START_DELAY     = 3'd2;
   localparam logic [2:0] REG_CRITICAL_ID_A   = 3'd3;
   localparam logic [2:0] REG_CRITICAL_ID_B   = 3'd4;
   localparam logic [2:0] REG_CRITICAL_ID_C   = 3'd5;
   localparam logic [2:0] REG_CRITICAL_ID_D   = 3'd6;
   localparam logic [2:0] REG_CRITICAL_ENABLE = 3'd7;

   typedef struct packed {
      logic [2:0]  kind;
      logic [2:0]  pattern_sel;
      logic [3:0]  frame_index;
      logic [7:0]  frame_leds;
      logic [15:0] frame_duration;
      logic        frame_is_last;
      logic [2:0]  vehicle_mode;
      logic [1:0]  power_op;
      logic [15:0] destination;
      logic [7:0]  entity_id;
      logic        entity_failed;
   } req_type;

   typedef struct packed {
      logic [7:0] led_drive;
      logic [2:0] active_pattern;
      logic       starting;
      logic       critical_latched;
   } rsp_type;

   typedef struct packed {
      logic [3:0]      led_count;
      logic [15:0]     system_id;
      logic [15:0]     start_delay_ms;
      logic [3:0][7:0] critical_id;
      logic [3:0]      critical_enable;
   } cfg_type;

   typedef struct packed {
      logic        is_last;
      logic [15:0] duration;
      logic [7:0]  leds;
   } frame_type;

endpackage

### rtl/lps_csr.sv
// ----------------------------------------------------------------------------
// lps_csr
// APB-style configuration registers; reset values, write decode, readback.
// ----------------------------------------------------------------------------
module lps_csr
   import lps_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready,
   output cfg_type                   cfg,
   output logic                      delay_load
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[CSR_ADDR_WIDTH-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign delay_load = wr_en && (reg_idx == REG_START_DELAY);
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_LED_COUNT:       cfg_in.led_count       = csr_pwdata[3:0];
            REG_SYSTEM_ID:       cfg_in.system_id       = csr_pwdata[15:0];
            REG_START_DELAY:     cfg_in.start_delay_ms  = csr_pwdata[15:0];
            REG_CRITICAL_ID_A:   cfg_in.critical_id[0]  = csr_pwdata[7:0];
            REG_CRITICAL_ID_B:   cfg_in.critical_id[1]  = csr_pwdata[7:0];
            REG_CRITICAL_ID_C:   cfg_in.critical_id[2]  = csr_pwdata[7:0];
            REG_CRITICAL_ID_D:   cfg_in.critical_id[3]  = csr_pwdata[7:0];
            REG_CRITICAL_ENABLE: cfg_in.critical_enable = csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_LED_COUNT:       csr_prdata = {28'd0, cfg_ff.led_count};
         REG_SYSTEM_ID:       csr_prdata = {16'd0, cfg_ff.system_id};
         REG_START_DELAY:     csr_prdata = {16'd0, cfg_ff.start_delay_ms};
         REG_CRITICAL_ID_A:   csr_prdata = {24'd0, cfg_ff.critical_id[0]};
         REG_CRITICAL_ID_B:   csr_prdata = {24'd0, cfg_ff.critical_id[1]};
         REG_CRITICAL_ID_C:   csr_prdata = {24'd0, cfg_ff.critical_id[2]};
         REG_CRITICAL_ID_D:   csr_prdata = {24'd0, cfg_ff.critical_id[3]};
         REG_CRITICAL_ENABLE: csr_prdata = {28'd0, cfg_ff.critical_enable};
         default:             csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.led_count       <= LED_COUNT_RESET;
         cfg_ff.system_id       <= 16'd0;
         cfg_ff.start_delay_ms  <= START_DELAY_RESET;
         cfg_ff.critical_id     <= '0;
         cfg_ff.critical_enable <= 4'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/lps_rsp_fifo.sv
// ----------------------------------------------------------------------------
// lps_rsp_fifo
// Small result queue that decouples the sequencer from result back-pressure.
// ----------------------------------------------------------------------------
module lps_rsp_fifo
   import lps_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  rsp_type    push_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_payload,
   output logic [1:0] level
);

   localparam logic [1:0] LAST_SLOT = 2'(FIFO_DEPTH - 1);

   rsp_type    slot_ff [FIFO_DEPTH];
   logic [1:0] wr_ptr_ff;
   logic [1:0] rd_ptr_ff;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       pop;

   assign rsp_valid   = (count_ff != 2'd0);
   assign rsp_payload = slot_ff[rd_ptr_ff];
   assign pop         = rsp_valid & rsp_ready;
   assign level       = count_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_SLOT) ? 2'd0 : wr_ptr_ff + 2'd1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_SLOT) ? 2'd0 : rd_ptr_ff + 2'd1;
         end
      end
   end

endmodule

### rtl/led_pattern_sequencer_core.sv
// ----------------------------------------------------------------------------
// led_pattern_sequencer_core
// LED blink pattern player: frames live in a one-port-read synchronous frame
// store, events choose the pending pattern, 1 ms ticks step through frames.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                       | Handshake     | Transaction
//  --------+-----------------------------+---------------+--------------------
//  req     | req_valid/ready/payload     | valid/ready   | tick or event item
//  rsp     | rsp_valid/ready/payload     | valid/ready   | LED + status result
//  csr     | csr_psel..pwdata/prdata     | APB, pready=1 | register write/read
//
//  Rate: one transaction per cycle while req_ready is high; its result goes
//  through the frame store read, then the LED update and queue write, before it can be taken.
//  Read data is forwarded, so back-to-back ticks never wait on each other.
//  Reset: synchronous; the frame store is not cleared.
//  Stalls: req_ready drops when the 3-entry result queue plus the transaction
//  in the read stage leave no room; a stalled rsp side loses nothing.
// ----------------------------------------------------------------------------
module led_pattern_sequencer_core
   import lps_pkg::*;
#(
   parameter int NUM_PATTERNS = NUM_PATTERNS_DEF,
   parameter int MAX_FRAMES   = MAX_FRAMES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp_payload,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

   localparam int DEPTH = NUM_PATTERNS * MAX_FRAMES;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam logic [CW-1:0] LAST_CURSOR = CW'(MAX_FRAMES - 1);
   localparam logic [AW-1:0] FRAME_STEP  = AW'(MAX_FRAMES);

   // pattern/cursor to frame store address (constant multiply)
   function automatic logic [AW-1:0] frame_addr(input logic [2:0] pat,
                                                input logic [CW-1:0] cur);
      frame_addr = AW'(pat) * FRAME_STEP + AW'(cur);
   endfunction

   // low led_count bits set, clamped to the LED count supported
   function automatic logic [7:0] led_mask(input logic [3:0] count);
      logic [3:0] n;
      logic [7:0] m;
      n = (count > 4'(MAX_LEDS)) ? 4'(MAX_LEDS) : count;
      if (n > 4'd8) begin
         n = 4'd8;
      end
      for (int i = 0; i < 8; i++) begin
         m[i] = (4'(i) < n);
      end
      return m;
   endfunction

   // ---------------------------------------------------------------- config
   cfg_type cfg;
   logic    delay_load;

   lps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .delay_load  (delay_load)
   );

   // ----------------------------------------------------------- frame store
   frame_type store_mem [DEPTH];
   frame_type rd_data_ff;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   frame_type     wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   // ------------------------------------------------------ sequencer state
   logic          start_phase_ff,  start_phase_in;
   logic [15:0]   start_rem_ff,    start_rem_in;
   logic [2:0]    cur_pat_ff,      cur_pat_in;
   logic [2:0]    pend_pat_ff,     pend_pat_in;
   logic          pend_vld_ff,     pend_vld_in;
   logic [CW-1:0] cursor_ff,       cursor_in;
   logic [15:0]   hold_ff,         hold_in;
   logic          last_ff,         last_in;
   logic [7:0]    led_ff,          led_in;
   logic          crit_ff,         crit_in;
   logic          load_pend_ff;

   // current frame view: read data from the previous cycle wins over the copy
   logic [7:0]  led_eff;
   logic [15:0] hold_eff;
   logic        last_eff;

   assign led_eff  = load_pend_ff ? rd_data_ff.leds     : led_ff;
   assign hold_eff = load_pend_ff ? rd_data_ff.duration : hold_ff;
   assign last_eff = load_pend_ff ? rd_data_ff.is_last  : last_ff;

   logic accept;
   logic wr_in_range;
   logic wr_hits_cur;
   logic mode_blocked;
   logic crit_hit;

   assign accept = req_valid & req_ready;

   assign wr_in_range = ({29'd0, req_payload.pattern_sel} < 32'(NUM_PATTERNS))
                     && ({28'd0, req_payload.frame_index} < 32'(MAX_FRAMES));
   assign wr_hits_cur = (req_payload.pattern_sel == cur_pat_ff)
                     && (CW'(req_payload.frame_index) == cursor_ff);

   assign mode_blocked = crit_ff
                      || (pend_vld_ff && (pend_pat_ff == PTN_SHUTDOWN))
                      || (cur_pat_ff == PTN_SHUTDOWN);

   always_comb begin
      crit_hit = 1'b0;
      for (int k = 0; k < 4; k++) begin
         if (cfg.critical_enable[k] && (cfg.critical_id[k] == req_payload.entity_id)) begin
            crit_hit = 1'b1;
         end
      end
   end

   assign wr_addr = frame_addr(req_payload.pattern_sel, CW'(req_payload.frame_index));
   assign wr_data = '{is_last:  req_payload.frame_is_last,
                      duration: req_payload.frame_duration,
                      leds:     req_payload.frame_leds};
   assign rd_addr = frame_addr(cur_pat_in, cursor_in);

   always_comb begin
      start_phase_in = start_phase_ff;
      start_rem_in   = start_rem_ff;
      cur_pat_in     = cur_pat_ff;
      pend_pat_in    = pend_pat_ff;
      pend_vld_in    = pend_vld_ff;
      cursor_in      = cursor_ff;
      hold_in        = hold_eff;
      last_in        = last_eff;
      led_in         = led_eff;
      crit_in        = crit_ff;
      rd_en          = 1'b0;
      wr_en          = 1'b0;

      // start delay reload; the user must write registers only while nothing is in flight (not enforced here)
      if (delay_load && start_phase_ff) begin
         start_rem_in = csr_pwdata[15:0];
      end

      if (accept) begin
         case (req_payload.kind)
            KIND_TICK: begin
               if (start_phase_ff) begin
                  if (start_rem_ff > 16'd1) begin
                     start_rem_in = start_rem_ff - 16'd1;
                  end else begin
                     // delay over: pending (or normal) pattern from frame 0
                     start_rem_in   = 16'd0;
                     start_phase_in = 1'b0;
                     cur_pat_in     = pend_vld_ff ? pend_pat_ff : PTN_NORMAL;
                     pend_pat_in    = pend_vld_ff ? pend_pat_ff : PTN_NORMAL;
                     pend_vld_in    = 1'b0;
                     cursor_in      = '0;
                     rd_en          = 1'b1;
                  end
               end else if (hold_eff > 16'd1) begin
                  hold_in = hold_eff - 16'd1;
               end else begin
                  // hold over: next frame, or wrap with pending pattern switch
                  if (last_eff || (cursor_ff == LAST_CURSOR)) begin
                     if (pend_vld_ff) begin
                        cur_pat_in  = pend_pat_ff;
                        pend_vld_in = 1'b0;
                     end
                     cursor_in = '0;
                  end else begin
                     cursor_in = cursor_ff + CW'(1);
                  end
                  rd_en = 1'b1;
               end
            end
            KIND_FRAME_WRITE: begin
               if (wr_in_range) begin
                  wr_en = 1'b1;
                  // the shown frame keeps LEDs and hold, its end mark follows
                  if (wr_hits_cur) begin
                     last_in = req_payload.frame_is_last;
                  end
               end
            end
            KIND_VEHICLE_MODE: begin
               if (!mode_blocked) begin
                  case (req_payload.vehicle_mode)
                     MODE_SERVICE: begin
                        pend_pat_in = PTN_NORMAL;
                        pend_vld_in = 1'b1;
                     end
                     MODE_CALIBRATION: begin
                        pend_pat_in = PTN_PLAN_START;
                        pend_vld_in = 1'b1;
                     end
                     MODE_ERROR, MODE_BOOT: begin
                        pend_pat_in = PTN_ERROR;
                        pend_vld_in = 1'b1;
                     end
                     MODE_MANEUVER, MODE_EXTERNAL: begin
                        pend_pat_in = PTN_PLAN_EXEC;
                        pend_vld_in = 1'b1;
                     end
                     default: ;
                  endcase
               end
            end
            KIND_POWER_OP: begin
               if (req_payload.destination == cfg.system_id) begin
                  if (req_payload.power_op == POWER_DOWN_IP) begin
                     pend_pat_in = PTN_SHUTDOWN;
                     pend_vld_in = 1'b1;
                  end else if (req_payload.power_op == POWER_DOWN_ABORTED) begin
                     // abort: normal pattern at once, frame 0 unless still starting
                     cur_pat_in  = PTN_NORMAL;
                     pend_vld_in = 1'b0;
                     cursor_in   = '0;
                     rd_en       = !start_phase_ff;
                  end
               end
            end
            KIND_ENTITY_STATE: begin
               if (req_payload.entity_failed && crit_hit) begin
                  crit_in     = 1'b1;
                  pend_pat_in = PTN_FATAL;
                  pend_vld_in = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_phase_ff <= 1'b1;
         start_rem_ff   <= START_DELAY_RESET;
         cur_pat_ff     <= PTN_NORMAL;
         pend_pat_ff    <= PTN_NORMAL;
         pend_vld_ff    <= 1'b0;
         cursor_ff      <= '0;
         hold_ff        <= 16'd0;
         last_ff        <= 1'b0;
         led_ff         <= 8'hFF;
         crit_ff        <= 1'b0;
         load_pend_ff   <= 1'b0;
      end else begin
         start_phase_ff <= start_phase_in;
         start_rem_ff   <= start_rem_in;
         cur_pat_ff     <= cur_pat_in;
         pend_pat_ff    <= pend_pat_in;
         pend_vld_ff    <= pend_vld_in;
         cursor_ff      <= cursor_in;
         hold_ff        <= hold_in;
         last_ff        <= last_in;
         led_ff         <= led_in;
         crit_ff        <= crit_in;
         load_pend_ff   <= rd_en;
      end
   end

   // ------------------------------------------------------------ read stage
   // status fields are final at accept; LEDs are final once read data is in
   logic    b_vld_ff;
   rsp_type b_rsp_ff;
   rsp_type push_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else begin
         b_vld_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_rsp_ff.led_drive        <= 8'd0;
         b_rsp_ff.active_pattern   <= cur_pat_in;
         b_rsp_ff.starting         <= start_phase_in;
         b_rsp_ff.critical_latched <= crit_in;
      end
   end

   always_comb begin
      push_data           = b_rsp_ff;
      push_data.led_drive = led_eff & led_mask(cfg.led_count);
   end

   // ---------------------------------------------------------- result queue
   logic [1:0] fifo_level;

   lps_rsp_fifo u_rsp_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (b_vld_ff),
      .push_data   (push_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .level       (fifo_level)
   );

   // room for this transaction and the one in the read stage
   assign req_ready = (({1'b0, fifo_level} + {2'd0, b_vld_ff}) < 3'(FIFO_DEPTH));

endmodule

### verif/tb_led_pattern_sequencer_core.sv
// ----------------------------------------------------------------------------
// tb_led_pattern_sequencer_core
// Self-checking bench for the LED pattern sequencer: loads every frame of the
// frame store, walks the start phase, pattern switching, power and critical
// events, then runs random traffic under three idling schemes and several
// register settings, checking each result against an in-bench predictor.
// ----------------------------------------------------------------------------
module tb_led_pattern_sequencer_core
   import lps_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // codes the package leaves unnamed
   localparam logic [2:0] MODE_SPARE_LO     = 3'd6;
   localparam logic [2:0] MODE_SPARE_HI     = 3'd7;
   localparam logic [1:0] POWER_OP_OTHER    = 2'd2;
   localparam logic [2:0] KIND_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] KIND_UNUSED_LAST  = 3'd7;
   localparam logic [2:0] PTN_SPARE_LO      = 3'd6;
   localparam logic [2:0] PTN_SPARE_HI      = 3'd7;

   // keep lots of margin above the slowest legal run
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int          DRAIN_CYCLES = 4;   // result is registered in the read stage, then in the queue
   localparam int          HOLD_OFF_CYCLES = 60;

   // -------------------------------------------------------------------------
   // Predictor + expected result store
   // -------------------------------------------------------------------------
   class led_seq_scoreboard;
      frame_type   frames [NUM_PATTERNS_DEF*MAX_FRAMES_DEF];
      bit          in_start;
      logic [15:0] start_left;
      logic [2:0]  cur_pat;
      logic [2:0]  next_pat;
      bit          next_ok;
      logic [3:0]  cursor;
      logic [15:0] hold_left;
      bit          crit_seen;
      logic [7:0]  led_reg;

      logic [3:0]  led_count;
      logic [15:0] own_id;
      logic [15:0] delay_ms;
      logic [7:0]  crit_id [4];
      logic [3:0]  crit_en;

      rsp_type     status_q[$];
      int          mismatches;
      int          checked;
      int          items;

      function new();
         led_count   = LED_COUNT_RESET;
         own_id      = '0;
         delay_ms    = START_DELAY_RESET;
         foreach (crit_id[k]) crit_id[k] = '0;
         crit_en     = '0;
         in_start    = 1'b1;
         start_left  = START_DELAY_RESET;
         cur_pat     = PTN_NORMAL;
         next_pat    = PTN_NORMAL;
         next_ok     = 1'b0;
         cursor      = '0;
         hold_left   = '0;
         crit_seen   = 1'b0;
         led_reg     = 8'hFF;
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10) $display("MISMATCH: %s", msg);
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] val);
         case (idx)
            REG_LED_COUNT: led_count = val[3:0];
            REG_SYSTEM_ID: own_id = val[15:0];
            REG_START_DELAY: begin
               delay_ms = val[15:0];
               if (in_start) start_left = delay_ms;
            end
            REG_CRITICAL_ID_A: crit_id[0] = val[7:0];
            REG_CRITICAL_ID_B: crit_id[1] = val[7:0];
            REG_CRITICAL_ID_C: crit_id[2] = val[7:0];
            REG_CRITICAL_ID_D: crit_id[3] = val[7:0];
            REG_CRITICAL_ENABLE: crit_en = val[3:0];
            default: ;
         endcase
      endfunction

      function bit crit_hit(logic [7:0] id);
         for (int k = 0; k < 4; k++)
            if (crit_en[k] && crit_id[k] == id) return 1'b1;
         return 1'b0;
      endfunction

      function int frame_addr();
         return int'(cur_pat) * MAX_FRAMES_DEF + int'(cursor);
      endfunction

      function void show_frame();
         frame_type f;
         f = frames[frame_addr()];
         led_reg   = f.leds;
         hold_left = f.duration;
      endfunction

      function void set_next(logic [2:0] p);
         next_pat = p;
         next_ok  = 1'b1;
      endfunction

      function void take_next();
         if (next_ok) begin
            cur_pat = next_pat;
            next_ok = 1'b0;
         end
      endfunction

      function void step_tick();
         frame_type f;
         if (in_start) begin
            if (start_left > 16'd1) begin
               start_left--;
               return;
            end
            start_left = '0;
            in_start   = 1'b0;
            if (!next_ok) set_next(PTN_NORMAL);
            take_next();
            cursor = '0;
            show_frame();
            return;
         end
         if (hold_left > 16'd1) begin
            hold_left--;
            return;
         end
         // end of hold: last mark or final slot wraps to frame 0
         f = frames[frame_addr()];
         if (f.is_last || cursor == 4'(MAX_FRAMES_DEF - 1)) begin
            take_next();
            cursor = '0;
         end else begin
            cursor++;
         end
         show_frame();
      endfunction

      function void note_item(req_type it);
         rsp_type    exp;
         frame_type  fw;
         int         n;
         logic [8:0] m;
         case (it.kind)
            KIND_TICK: step_tick();
            KIND_FRAME_WRITE: begin
               fw.is_last  = it.frame_is_last;
               fw.duration = it.frame_duration;
               fw.leds     = it.frame_leds;
               frames[int'(it.pattern_sel) * MAX_FRAMES_DEF + int'(it.frame_index)] = fw;
            end
            KIND_VEHICLE_MODE: begin
               if (!(crit_seen || (next_ok && next_pat == PTN_SHUTDOWN)
                     || cur_pat == PTN_SHUTDOWN)) begin
                  case (it.vehicle_mode)
                     MODE_SERVICE:              set_next(PTN_NORMAL);
                     MODE_CALIBRATION:          set_next(PTN_PLAN_START);
                     MODE_ERROR, MODE_BOOT:     set_next(PTN_ERROR);
                     MODE_MANEUVER, MODE_EXTERNAL: set_next(PTN_PLAN_EXEC);
                     default: ;
                  endcase
               end
            end
            KIND_POWER_OP: begin
               if (it.destination == own_id) begin
                  if (it.power_op == POWER_DOWN_IP) begin
                     set_next(PTN_SHUTDOWN);
                  end else if (it.power_op == POWER_DOWN_ABORTED) begin
                     cur_pat = PTN_NORMAL;
                     next_ok = 1'b0;
                     cursor  = '0;
                     if (!in_start) show_frame();
                  end
               end
            end
            KIND_ENTITY_STATE: begin
               if (it.entity_failed && crit_hit(it.entity_id)) begin
                  crit_seen = 1'b1;
                  set_next(PTN_FATAL);
               end
            end
            default: ;
         endcase
         n = (led_count > MAX_LEDS) ? MAX_LEDS : int'(led_count);
         m = (9'd1 << n) - 9'd1;
         exp.led_drive        = led_reg & m[7:0];
         exp.active_pattern   = cur_pat;
         exp.starting         = in_start;
         exp.critical_latched = crit_seen;
         status_q.insert(status_q.size(), exp);
         items++;
      endfunction

      function void check_status(rsp_type got);
         rsp_type exp;
         if (status_q.size() == 0) begin
            flag($sformatf("result %h with nothing outstanding", got));
            return;
         end
         exp = status_q.pop_front();
         checked++;
         if (got.led_drive !== exp.led_drive || got.active_pattern !== exp.active_pattern
             || got.starting !== exp.starting
             || got.critical_latched !== exp.critical_latched)
            flag($sformatf({"result %0d: leds exp %h act %h, pattern exp %0d act %0d, ",
                            "starting exp %0b act %0b, critical exp %0b act %0b"},
                           checked, exp.led_drive, got.led_drive, exp.active_pattern,
                           got.active_pattern, exp.starting, got.starting,
                           exp.critical_latched, got.critical_latched));
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT signals and instance
   // -------------------------------------------------------------------------
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   req_type                   req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   rsp_type                   rsp_payload;
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [31:0]               csr_pwdata = '0;
   logic [31:0]               csr_prdata;
   logic                      csr_pready;

   led_seq_scoreboard sb = new();

   int          send_idle_pct = 22;
   int          recv_idle_pct = 46;
   int          hold_offs_req = 0;   // bumped by the stimulus, NBA only
   int          hold_offs_done = 0;  // owned by the receiver process
   int          hold_left = 0;
   int          csr_writes = 0;
   int unsigned cycles = 0;

   led_pattern_sequencer_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycles, sb.status_q.size());
         $display("led_pattern_sequencer_core regression: fail");
         $finish;
      end
   end

   // Result side: check on handshake, then pick next ready. A hold-off
   // request parks ready low for a fixed stretch so the result queue backs
   // up into the request side.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) sb.check_status(rsp_payload);
         if (hold_offs_done < hold_offs_req) begin
            hold_offs_done++;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Item builders: every field starts random so all bits toggle, then the
   // fields that matter for the kind are set.
   // -------------------------------------------------------------------------
   function automatic req_type noise_item(logic [2:0] kind);
      logic [95:0] r;
      req_type     it;
      r  = {$urandom(), $urandom(), $urandom()};
      it = req_type'(r[$bits(req_type)-1:0]);
      it.kind = kind;
      return it;
   endfunction

   function automatic req_type frame_item(logic [2:0] sel, logic [3:0] idx,
                                          logic [7:0] leds, logic [15:0] dur, logic last);
      req_type it;
      it = noise_item(KIND_FRAME_WRITE);
      it.pattern_sel    = sel;
      it.frame_index    = idx;
      it.frame_leds     = leds;
      it.frame_duration = dur;
      it.frame_is_last  = last;
      return it;
   endfunction

   function automatic req_type mode_item(logic [2:0] mode);
      req_type it;
      it = noise_item(KIND_VEHICLE_MODE);
      it.vehicle_mode = mode;
      return it;
   endfunction

   function automatic req_type power_item(logic [1:0] op, logic [15:0] dst);
      req_type it;
      it = noise_item(KIND_POWER_OP);
      it.power_op    = op;
      it.destination = dst;
      return it;
   endfunction

   function automatic req_type entity_item(logic [7:0] id, logic failed);
      req_type it;
      it = noise_item(KIND_ENTITY_STATE);
      it.entity_id     = id;
      it.entity_failed = failed;
      return it;
   endfunction

   // Mostly ticks so patterns actually play; played patterns get short holds
   // so they wrap often. Critical hits are held back until the last chunk,
   // since a latched failure blocks mode changes for the rest of the run.
   function automatic req_type random_item(bit allow_crit);
      int         pick;
      int         sub;
      logic [2:0] sel;
      logic [1:0] op;
      logic [15:0] dst;
      logic [7:0] id;
      req_type    it;
      pick = $urandom_range(0, 99);
      if (pick < 58) begin
         it = noise_item(KIND_TICK);
      end else if (pick < 68) begin
         sel = 3'($urandom_range(0, 7));
         it  = frame_item(sel, 4'($urandom_range(0, 15)), 8'($urandom()),
                          (sel <= PTN_PLAN_EXEC) ? 16'($urandom_range(0, 4))
                                                 : 16'($urandom()),
                          ($urandom_range(0, 3) == 0));
      end else if (pick < 78) begin
         it = mode_item(3'($urandom_range(0, 7)));
      end else if (pick < 90) begin
         sub = $urandom_range(0, 9);
         if (sub < 4)      op = POWER_DOWN_IP;
         else if (sub < 8) op = POWER_DOWN_ABORTED;
         else              op = POWER_OP_OTHER | 2'($urandom_range(0, 1));
         dst = ($urandom_range(0, 4) != 0) ? sb.own_id : 16'($urandom());
         it = power_item(op, dst);
      end else if (pick < 98) begin
         id = ($urandom_range(0, 1) != 0) ? sb.crit_id[$urandom_range(0, 3)]
                                          : 8'($urandom());
         it = entity_item(id, 1'($urandom_range(0, 1)));
         if (!allow_crit && sb.crit_hit(id)) it.entity_failed = 1'b0;
      end else begin
         it = noise_item(3'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST)));
      end
      return it;
   endfunction

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------
   // Offer one transaction, with optional idle cycles first. Valid is left
   // high on return; the next call or drain_results takes it from there.
   task automatic push_item(req_type it);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= it;
      do @(posedge clock); while (!req_ready);
      sb.note_item(it);
   endtask

   // Stop offering and wait until every outstanding result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (sb.status_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // APB write then read-back of the same register.
   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      logic [31:0] want;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.write_reg(idx, val);
      csr_writes++;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_LED_COUNT, REG_CRITICAL_ENABLE: want = val & 32'h0000_000F;
         REG_SYSTEM_ID, REG_START_DELAY:     want = val & 32'h0000_FFFF;
         default:                            want = val & 32'h0000_00FF;
      endcase
      if (csr_prdata !== want)
         sb.flag($sformatf("register %0d read back exp %h act %h", idx, want, csr_prdata));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic run_random(int count, bit allow_crit);
      int      done;
      req_type it;
      done = 0;
      while (done < count) begin
         it = random_item(allow_crit);
         push_item(it);
         if (it.kind <= KIND_ENTITY_STATE) done++;
      end
   endtask

   // Park the result side while the sender keeps offering back to back, so
   // the block fills and drops req_ready; then pause until all is drained.
   task automatic hold_off_burst(bit allow_crit);
      int saved_pct;
      saved_pct     = send_idle_pct;
      send_idle_pct = 0;
      hold_offs_req <= hold_offs_req + 1;
      run_random(24, allow_crit);
      send_idle_pct = saved_pct;
      drain_results();
   endtask

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // --- phase 1: sender idles 22%, receiver 46% -------------------------
      // Long start delay first; every register gets a value.
      csr_write(REG_START_DELAY, 32'd65535);
      csr_write(REG_LED_COUNT, 32'd8);
      csr_write(REG_SYSTEM_ID, 32'd0);
      csr_write(REG_CRITICAL_ID_A, 32'd0);
      csr_write(REG_CRITICAL_ID_B, 32'd255);
      csr_write(REG_CRITICAL_ID_C, 32'h5A);
      csr_write(REG_CRITICAL_ID_D, 32'hA5);
      csr_write(REG_CRITICAL_ENABLE, 32'd0);

      // Fill the whole frame store while still in the start phase, so no
      // unwritten frame is ever loaded. The plan-exec pattern gets no last
      // mark and runs all sixteen frames before wrapping.
      for (int p = 0; p < NUM_PATTERNS_DEF; p++) begin
         for (int f = 0; f < MAX_FRAMES_DEF; f++) begin
            push_item(frame_item(3'(p), 4'(f), 8'($urandom()),
                                 (p <= PTN_PLAN_EXEC) ? 16'($urandom_range(0, 3))
                                                      : 16'($urandom()),
                                 (p != PTN_PLAN_EXEC) && ($urandom_range(0, 3) == 0)));
         end
      end

      // start phase counting, abort during start phase (no frame load)
      push_item(noise_item(KIND_TICK));
      push_item(noise_item(KIND_TICK));
      push_item(mode_item(MODE_MANEUVER));
      push_item(power_item(POWER_DOWN_ABORTED, sb.own_id));
      push_item(mode_item(MODE_EXTERNAL));
      drain_results();
      // delay rewrite reloads the counter: two more ticks end the start phase
      csr_write(REG_START_DELAY, 32'd2);
      push_item(noise_item(KIND_TICK));
      push_item(noise_item(KIND_TICK));
      // ignored items: spare modes, unused kinds, other power op, foreign
      // destination, non-critical failure
      push_item(mode_item(MODE_SPARE_LO));
      push_item(mode_item(MODE_SPARE_HI));
      push_item(noise_item(KIND_UNUSED_FIRST));
      push_item(noise_item(KIND_UNUSED_LAST));
      push_item(power_item(POWER_OP_OTHER, sb.own_id));
      push_item(power_item(POWER_DOWN_IP, sb.own_id ^ 16'h1234));
      push_item(entity_item(8'd0, 1'b1));
      // frame field extremes, into patterns that never play
      push_item(frame_item(PTN_SPARE_HI, 4'(MAX_FRAMES_DEF - 1), 8'hFF, 16'hFFFF, 1'b1));
      push_item(frame_item(PTN_SPARE_LO, 4'(MAX_FRAMES_DEF - 1), 8'h00, 16'h0000, 1'b0));
      // pending pattern replaced by later modes
      push_item(mode_item(MODE_BOOT));
      push_item(mode_item(MODE_SERVICE));
      push_item(mode_item(MODE_CALIBRATION));
      // shutdown pending blocks modes; abort switches to normal at once
      push_item(power_item(POWER_DOWN_IP, sb.own_id));
      push_item(mode_item(MODE_ERROR));
      push_item(noise_item(KIND_TICK));
      push_item(noise_item(KIND_TICK));
      push_item(power_item(POWER_DOWN_ABORTED, sb.own_id));
      push_item(mode_item(MODE_CALIBRATION));
      push_item(noise_item(KIND_TICK));
      drain_results();

      csr_write(REG_LED_COUNT, 32'd15);   // above MAX_LEDS: clamps
      run_random(120, 1'b0);
      drain_results();
      csr_write(REG_LED_COUNT, 32'd1);
      run_random(120, 1'b0);
      drain_results();

      // --- phase 2: sender idles 46%, receiver 22% -------------------------
      send_idle_pct = 46;
      recv_idle_pct = 22;
      csr_write(REG_LED_COUNT, 32'd0);    // no LED driven
      csr_write(REG_SYSTEM_ID, 32'd65535);
      csr_write(REG_START_DELAY, 32'd0);  // outside start phase: stored only
      csr_write(REG_CRITICAL_ENABLE, 32'b1010);
      run_random(60, 1'b0);
      drain_results();
      csr_write(REG_LED_COUNT, 32'd5);
      run_random(130, 1'b0);
      hold_off_burst(1'b0);
      run_random(116, 1'b0);
      drain_results();

      // --- phase 3: no idling on either side -------------------------------
      send_idle_pct = 0;
      recv_idle_pct = 0;
      csr_write(REG_LED_COUNT, 32'd8);
      csr_write(REG_SYSTEM_ID, 32'($urandom_range(1, 65534)));
      csr_write(REG_CRITICAL_ID_C, 32'($urandom_range(0, 255)));
      csr_write(REG_CRITICAL_ID_D, 32'($urandom_range(0, 255)));
      csr_write(REG_CRITICAL_ENABLE, 32'b0101);
      csr_write(REG_START_DELAY, 32'(START_DELAY_RESET));
      run_random(150, 1'b0);
      hold_off_burst(1'b0);
      csr_write(REG_CRITICAL_ENABLE, 32'hF);
      // critical failures allowed from here on; make sure one lands
      run_random(80, 1'b1);
      push_item(entity_item(sb.crit_id[0], 1'b1));
      push_item(mode_item(MODE_MANEUVER));   // ignored once latched
      run_random(20, 1'b1);

      drain_results();
      repeat (8) @(posedge clock);

      $display("run covered %0d transactions, %0d results checked, %0d register writes",
               sb.items, sb.checked, csr_writes);
      $display("hold-offs %0d, final pattern %0d, critical latched %0b, mismatches %0d",
               hold_offs_done, sb.cur_pat, sb.crit_seen, sb.mismatches);
      if (sb.mismatches == 0 && sb.status_q.size() == 0) begin
         $display("led_pattern_sequencer_core regression: pass");
      end else begin
         $display("led_pattern_sequencer_core regression: fail");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/lps_pkg.sv
rtl/lps_csr.sv
rtl/lps_rsp_fifo.sv
rtl/led_pattern_sequencer_core.sv
verif/tb_led_pattern_sequencer_core.sv
